### rtl/fgpe_pkg.sv
`timescale 1ns / 1ps

package fgpe_pkg;

	// Default sizing of the glyph store and glyph limits
	localparam int STORE_BYTES_DEF = 1024;
	localparam int MAX_WIDTH_DEF   = 8;
	localparam int MAX_HEIGHT_DEF  = 8;

	// Field widths
	localparam int LOAD_ADDR_W = 10;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 8;
	localparam int COORD_W     = 16;
	localparam int COLOR_W     = 16;
	localparam int CFG_DATA_W  = 4;
	localparam int CFG_INDEX_W = 2;

	// Row addresses reach (255 - 32) * 15 + 7, and compare against up to 4096
	localparam int ADDR_W = 13;

	// Column and row counters cover glyphs of up to 8 by 8
	localparam int CNT_W = 3;

	localparam logic [CODE_W-1:0] FIRST_CODE = 8'h20;

	localparam logic [CFG_DATA_W-1:0] RESET_FONT_WIDTH  = 4'd8;
	localparam logic [CFG_DATA_W-1:0] RESET_FONT_HEIGHT = 4'd8;

	localparam logic [CFG_INDEX_W-1:0] REG_FONT_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FONT_HEIGHT = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Request bundle from the scanner to the glyph store
	typedef struct packed {
		logic                   wr_en;
		logic [LOAD_ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0]      wr_data;
		logic                   rd_en;
		logic [ADDR_W-1:0]      rd_addr;
	} store_req_t;

endpackage

### rtl/fgpe_store.sv
`timescale 1ns / 1ps

module fgpe_store #(
	parameter int STORE_BYTES = fgpe_pkg::STORE_BYTES_DEF
) (
	input  logic                        clk,
	input  fgpe_pkg::store_req_t        req,
	output logic [fgpe_pkg::BYTE_W-1:0] rd_data
);
	import fgpe_pkg::*;

	localparam int IDX_W = $clog2(STORE_BYTES);

	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [ADDR_W-1:0] wr_addr_ext;
	logic              wr_in_range;
	logic              rd_in_range;
	logic [BYTE_W-1:0] rd_byte_q;
	logic              rd_zero_q;

	assign wr_addr_ext = ADDR_W'(req.wr_addr);
	assign wr_in_range = (wr_addr_ext < ADDR_W'(STORE_BYTES));
	assign rd_in_range = (req.rd_addr < ADDR_W'(STORE_BYTES));

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_in_range) begin
			mem[wr_addr_ext[IDX_W-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_byte_q <= mem[req.rd_addr[IDX_W-1:0]];
			rd_zero_q <= !rd_in_range;
		end
	end

	// Rows past the end of the store read as zero
	assign rd_data = rd_zero_q ? '0 : rd_byte_q;

endmodule

### rtl/font_glyph_pixel_expander.sv
// Load items write the store and produce nothing; input is ready again next cycle.
// Draws scan a w by h glyph row by row: each row takes a store read, a capture of the
// byte and a scan of its columns; a flush state then sends the held pixel and the
// block returns to idle, where the next transfer is taken.
// One draw item is worked at a time; output stalls can hold the column scan and the flush.
// Reset clears the font registers to 8 by 8 and idles the scanner; the glyph
// store is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module font_glyph_pixel_expander #(
	parameter int STORE_BYTES = fgpe_pkg::STORE_BYTES_DEF,
	parameter int MAX_WIDTH   = fgpe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = fgpe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fgpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fgpe_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [fgpe_pkg::LOAD_ADDR_W-1:0] store_address,
	input  logic [fgpe_pkg::BYTE_W-1:0]      store_byte,
	input  logic [fgpe_pkg::CODE_W-1:0]      char_code,
	input  logic [fgpe_pkg::COORD_W-1:0]     origin_x,
	input  logic [fgpe_pkg::COORD_W-1:0]     origin_y,
	input  logic [fgpe_pkg::COLOR_W-1:0]     ink_color,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fgpe_pkg::COORD_W-1:0]     pixel_x,
	output logic [fgpe_pkg::COORD_W-1:0]     pixel_y,
	output logic [fgpe_pkg::COLOR_W-1:0]     pixel_color,
	output logic                             last_pixel
);
	import fgpe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	// Font geometry registers, as written
	logic [CFG_DATA_W-1:0] font_width_q;
	logic [CFG_DATA_W-1:0] font_height_q;

	// Geometry clamped to the glyph limits
	logic [CFG_DATA_W-1:0] width_sat;
	logic [CFG_DATA_W-1:0] height_sat;

	// Latched for the glyph in flight
	logic [CNT_W-1:0]   last_col_q;
	logic [CNT_W-1:0]   last_row_q;
	logic [COORD_W-1:0] origin_x_q;
	logic [COLOR_W-1:0] ink_q;

	// Scan position
	logic [ADDR_W-1:0]  row_addr_q;
	logic [CNT_W-1:0]   col_q;
	logic [CNT_W-1:0]   row_q;
	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;
	logic [BYTE_W-1:0]  bits_q;

	// One set pixel held back until we know whether another follows
	logic               pend_valid_q;
	logic [COORD_W-1:0] pend_x_q;
	logic [COORD_W-1:0] pend_y_q;

	// Output register
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_last_q;

	logic                    in_xfer;
	logic                    is_draw;
	logic [CODE_W-1:0]       code_off;
	logic [ADDR_W-1:0]       glyph_base;
	logic                    out_free;
	logic                    hit;
	logic                    scan_step;
	logic                    row_done;
	logic                    glyph_done;
	logic                    out_load;
	store_req_t              store_req;
	logic [BYTE_W-1:0]       store_rd_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign is_draw   = (operation == OP_DRAW);

	assign width_sat  = (font_width_q > CFG_DATA_W'(MAX_WIDTH)) ?
		CFG_DATA_W'(MAX_WIDTH) : font_width_q;
	assign height_sat = (font_height_q > CFG_DATA_W'(MAX_HEIGHT)) ?
		CFG_DATA_W'(MAX_HEIGHT) : font_height_q;

	// First row of the glyph: (code - 32) * height, using the unclamped height
	assign code_off   = char_code - FIRST_CODE;
	assign glyph_base = ADDR_W'(code_off) * ADDR_W'(font_height_q);

	// The output register can take a pixel this cycle
	assign out_free = !out_valid_q || out_ready;

	// The leftmost remaining column of the row is set
	assign hit = bits_q[BYTE_W-1];

	// Advance the scan unless a found pixel must push the held one out and cannot
	assign scan_step  = (state_q == ST_SCAN) && (!(hit && pend_valid_q) || out_free);
	assign row_done   = (col_q == last_col_q);
	assign glyph_done = row_done && (row_q == last_row_q);

	// A new pixel enters the output register this cycle
	assign out_load = (scan_step && hit && pend_valid_q) ||
		((state_q == ST_FLUSH) && pend_valid_q && out_free);

	always_comb begin
		store_req.wr_en   = in_xfer && !is_draw;
		store_req.wr_addr = store_address;
		store_req.wr_data = store_byte;
		store_req.rd_en   = (state_q == ST_READ);
		store_req.rd_addr = row_addr_q;
	end

	fgpe_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.req    (store_req),
		.rd_data(store_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			font_width_q  <= RESET_FONT_WIDTH;
			font_height_q <= RESET_FONT_HEIGHT;
			last_col_q    <= '0;
			last_row_q    <= '0;
			origin_x_q    <= '0;
			ink_q         <= '0;
			row_addr_q    <= '0;
			col_q         <= '0;
			row_q         <= '0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			bits_q        <= '0;
			pend_valid_q  <= 1'b0;
			pend_x_q      <= '0;
			pend_y_q      <= '0;
			out_valid_q   <= 1'b0;
			out_x_q       <= '0;
			out_y_q       <= '0;
			out_color_q   <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// Configuration transfers; unknown indexes drop
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FONT_WIDTH:  font_width_q  <= cfg_data;
					REG_FONT_HEIGHT: font_height_q <= cfg_data;
					default: ;
				endcase
			end

			// Retire the output once the consumer takes it, unless a new pixel replaces it
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					// Loads write the store directly; draws below the first
					// printable code or with an empty box produce nothing
					if (in_xfer && is_draw && (char_code >= FIRST_CODE) &&
						(width_sat != '0) && (height_sat != '0)) begin
						last_col_q <= CNT_W'(width_sat - CFG_DATA_W'(1));
						last_row_q <= CNT_W'(height_sat - CFG_DATA_W'(1));
						origin_x_q <= origin_x;
						ink_q      <= ink_color;
						row_addr_q <= glyph_base;
						row_q      <= '0;
						cur_y_q    <= origin_y;
						state_q    <= ST_READ;
					end
				end

				ST_READ: begin
					// Store read is in flight
					state_q <= ST_LOAD;
				end

				ST_LOAD: begin
					// Capture the row into the column shifter
					bits_q  <= store_rd_data;
					col_q   <= '0;
					cur_x_q <= origin_x_q;
					state_q <= ST_SCAN;
				end

				ST_SCAN: begin
					if (scan_step) begin
						if (hit) begin
							// Push the held pixel out, then hold the new one
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_x_q     <= pend_x_q;
								out_y_q     <= pend_y_q;
								out_color_q <= ink_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_x_q     <= cur_x_q;
							pend_y_q     <= cur_y_q;
						end
						bits_q  <= {bits_q[BYTE_W-2:0], 1'b0};
						col_q   <= col_q + CNT_W'(1);
						cur_x_q <= cur_x_q + COORD_W'(1);
						if (row_done) begin
							row_addr_q <= row_addr_q + ADDR_W'(1);
							row_q      <= row_q + CNT_W'(1);
							cur_y_q    <= cur_y_q + COORD_W'(1);
							state_q    <= glyph_done ? ST_FLUSH : ST_READ;
						end
					end
				end

				ST_FLUSH: begin
					// The held pixel, if any, is the last of the glyph
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_x_q      <= pend_x_q;
						out_y_q      <= pend_y_q;
						out_color_q  <= ink_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_color = out_color_q;
	assign last_pixel  = out_last_q;

endmodule

### test/tb_font_glyph_pixel_expander.sv
`timescale 1ns / 1ps

module tb_font_glyph_pixel_expander;
	import fgpe_pkg::*;

	localparam int IDLE_PCT      = 10;      // percent of cycles a side holds off
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 120;     // longer than the worst glyph scan, 8 by 8
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_CAP    = 100;
	localparam int PHASE_ITEMS   = 8;
	localparam int NUM_PHASES    = 10;
	localparam int STEADY_PHASE  = 7;       // no idling on either side in this phase
	localparam int CODE_SPAN     = 2**CODE_W - 1 - int'(FIRST_CODE);

	localparam logic [BYTE_W-1:0] LEFT_BIT = 8'h80;

	// Register indexes past the end of the map; writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	typedef struct packed {
		logic                   op;
		logic [LOAD_ADDR_W-1:0] addr;
		logic [BYTE_W-1:0]      byt;
		logic [CODE_W-1:0]      code;
		logic [COORD_W-1:0]     ox;
		logic [COORD_W-1:0]     oy;
		logic [COLOR_W-1:0]     ink;
	} glyph_cmd_t;

	// One row of the directed table: a register write or an input item, with
	// the result typed in where it is obvious (nothing, or one single pixel)
	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		glyph_cmd_t             cmd;
		bit                     typed;
		bit                     has_pixel;
		pixel_t                 pixel;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   operation = OP_LOAD;
	logic [LOAD_ADDR_W-1:0] store_address = '0;
	logic [BYTE_W-1:0]      store_byte = '0;
	logic [CODE_W-1:0]      char_code = '0;
	logic [COORD_W-1:0]     origin_x = '0;
	logic [COORD_W-1:0]     origin_y = '0;
	logic [COLOR_W-1:0]     ink_color = '0;

	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [COORD_W-1:0]     pixel_x;
	logic [COORD_W-1:0]     pixel_y;
	logic [COLOR_W-1:0]     pixel_color;
	logic                   last_pixel;

	// Shadow of the block: glyph store contents, which bytes hold real data,
	// and the two font registers
	logic [BYTE_W-1:0]     glyph_rows [STORE_BYTES_DEF];
	bit                    row_loaded [STORE_BYTES_DEF];
	logic [CFG_DATA_W-1:0] scan_width = RESET_FONT_WIDTH;
	logic [CFG_DATA_W-1:0] scan_height = RESET_FONT_HEIGHT;

	pixel_t expected_pixels [$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	bit     steady_flow = 1'b0;

	step_t directed_plan [24];

	logic [CFG_DATA_W-1:0] phase_w [NUM_PHASES] = '{4'd8, 4'd1, 4'd15, 4'd8, 4'd1,
		4'd0, 4'd6, 4'd8, 4'd5, 4'd3};
	logic [CFG_DATA_W-1:0] phase_h [NUM_PHASES] = '{4'd8, 4'd1, 4'd15, 4'd1, 4'd8,
		4'd6, 4'd0, 4'd8, 4'd7, 4'd2};

	font_glyph_pixel_expander u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.store_address(store_address),
		.store_byte   (store_byte),
		.char_code    (char_code),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.ink_color    (ink_color),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.last_pixel   (last_pixel)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expand one glyph into the pixels the block must emit, in scan order:
	// rows top to bottom, columns from the MSB down. The row address uses the
	// raw height register, while the scan itself is clamped to 8 by 8.
	function automatic void rasterize_glyph(input logic [CODE_W-1:0] code,
			input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
			input logic [COLOR_W-1:0] ink);
		int          cols;
		int          rows;
		int          base;
		int          addr;
		int          first;
		logic [7:0]  bits;
		pixel_t      px;
		first = expected_pixels.size();
		if (code < FIRST_CODE)
			return;
		cols = (scan_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(scan_width);
		rows = (scan_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(scan_height);
		base = (int'(code) - int'(FIRST_CODE)) * int'(scan_height);
		for (int r = 0; r < rows; r++) begin
			addr = base + r;
			// rows past the end of the store read as blank
			bits = (addr < STORE_BYTES_DEF) ? glyph_rows[addr] : '0;
			for (int c = 0; c < cols; c++) begin
				if ((bits & (LEFT_BIT >> c)) != 0) begin
					px.x     = ox + COORD_W'(c);
					px.y     = oy + COORD_W'(r);
					px.color = ink;
					px.last  = 1'b0;
					expected_pixels.push_back(px);
				end
			end
		end
		// mark the final pixel of a non-empty glyph
		if (expected_pixels.size() > first)
			expected_pixels[expected_pixels.size() - 1].last = 1'b1;
	endfunction

	function automatic step_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = '{default: '0};
		s.is_cfg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	function automatic step_t load_row(input logic [LOAD_ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] byt);
		step_t s;
		s = '{default: '0};
		s.cmd.op   = OP_LOAD;
		s.cmd.addr = addr;
		s.cmd.byt  = byt;
		return s;
	endfunction

	// A draw checked against the predictor
	function automatic step_t draw_row(input logic [CODE_W-1:0] code,
			input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
			input logic [COLOR_W-1:0] ink);
		step_t s;
		s = '{default: '0};
		s.cmd.op   = OP_DRAW;
		s.cmd.code = code;
		s.cmd.ox   = ox;
		s.cmd.oy   = oy;
		s.cmd.ink  = ink;
		return s;
	endfunction

	// A draw that must emit nothing at all
	function automatic step_t draw_blank(input logic [CODE_W-1:0] code,
			input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
			input logic [COLOR_W-1:0] ink);
		step_t s;
		s = draw_row(code, ox, oy, ink);
		s.typed = 1'b1;
		return s;
	endfunction

	// A draw that must emit exactly the one given pixel
	function automatic step_t draw_single(input logic [CODE_W-1:0] code,
			input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
			input logic [COLOR_W-1:0] ink, input pixel_t px);
		step_t s;
		s = draw_blank(code, ox, oy, ink);
		s.has_pixel = 1'b1;
		s.pixel     = px;
		return s;
	endfunction

	// Coordinates lean toward the top of the range so the 16-bit wrap is hit
	function automatic logic [COORD_W-1:0] pick_coord();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			return COORD_W'($urandom_range(16'hFFF0, 16'hFFFF));
		if (roll < 35)
			return COORD_W'($urandom_range(0, 15));
		return COORD_W'($urandom);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_row_bits();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return '0;
		if (roll < 35)
			return '1;
		return BYTE_W'($urandom);
	endfunction

	// Fill every field at random; the fields an operation does not use must be ignored
	function automatic glyph_cmd_t random_cmd(input logic op);
		glyph_cmd_t c;
		c.op   = op;
		c.addr = LOAD_ADDR_W'($urandom);
		c.byt  = pick_row_bits();
		c.code = CODE_W'($urandom);
		c.ox   = pick_coord();
		c.oy   = pick_coord();
		c.ink  = COLOR_W'($urandom);
		return c;
	endfunction

	task automatic flag_mismatch(input string field, input logic [15:0] want,
			input logic [15:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// Drop valid on both request channels and hold until every pixel is back
	task automatic wait_drained();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Write a font register while the block is idle. A draw that yields no
	// pixels may still be scanning, so let a full glyph time pass first.
	task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_FONT_WIDTH)
			scan_width = val;
		else if (idx == REG_FONT_HEIGHT)
			scan_height = val;
	endtask

	// Present one item and wait for its transfer. Valid stays high on return so
	// a following item can go out back to back; the next caller lowers it.
	task automatic send_item(input glyph_cmd_t cmd, input bit predict);
		cfg_valid <= 1'b0;
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= cmd.op;
		store_address <= cmd.addr;
		store_byte    <= cmd.byt;
		char_code     <= cmd.code;
		origin_x      <= cmd.ox;
		origin_y      <= cmd.oy;
		ink_color     <= cmd.ink;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (cmd.op == OP_LOAD) begin
			glyph_rows[cmd.addr] = cmd.byt;
			row_loaded[cmd.addr] = 1'b1;
		end else if (predict) begin
			rasterize_glyph(cmd.code, cmd.ox, cmd.oy, cmd.ink);
		end
	endtask

	// Random traffic under the current font shape. Most of it is a glyph load
	// followed by its draw; the rest is stray loads, unprintable codes and
	// pauses until the pixel stream is empty.
	task automatic run_phase(input int budget);
		int         sent;
		int         roll;
		int         lim;
		int         rows;
		int         base;
		int         addr;
		bit         refresh;
		glyph_cmd_t draw;
		glyph_cmd_t load;
		sent = 0;
		while (sent < budget) begin
			roll = $urandom_range(0, 99);
			draw = random_cmd(OP_DRAW);
			if (roll < 65) begin
				// favor codes whose rows sit inside the store; the rest may run off its end
				lim = (scan_height == 0) ? CODE_SPAN : (STORE_BYTES_DEF - 1) / int'(scan_height);
				if (lim > CODE_SPAN)
					lim = CODE_SPAN;
				if (roll < 50)
					draw.code = CODE_W'(int'(FIRST_CODE) + $urandom_range(0, lim));
				else
					draw.code = CODE_W'($urandom_range(int'(FIRST_CODE), 2**CODE_W - 1));
				rows = (scan_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(scan_height);
				base = (int'(draw.code) - int'(FIRST_CODE)) * int'(scan_height);
				refresh = ($urandom_range(0, 1) == 1);
				// never let the scan read a store byte that holds no data yet
				for (int r = 0; r < rows; r++) begin
					addr = base + r;
					if (addr < STORE_BYTES_DEF && (refresh || !row_loaded[addr])) begin
						load      = random_cmd(OP_LOAD);
						load.addr = LOAD_ADDR_W'(addr);
						send_item(load, 1'b1);
						sent++;
					end
				end
				send_item(draw, 1'b1);
				sent++;
			end else if (roll < 75) begin
				draw.code = CODE_W'($urandom_range(0, int'(FIRST_CODE) - 1));
				send_item(draw, 1'b1);
				sent++;
			end else if (roll < 92) begin
				send_item(random_cmd(OP_LOAD), 1'b1);
				sent++;
			end else begin
				wait_drained();
			end
		end
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);

	// Compare each pixel transfer with the oldest pending expectation
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_CAP)
					$display("%0t: unexpected pixel, expected none, actual x %h y %h color %h last %b",
						$time, pixel_x, pixel_y, pixel_color, last_pixel);
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_x !== want.x)
					flag_mismatch("pixel_x", want.x, pixel_x);
				if (pixel_y !== want.y)
					flag_mismatch("pixel_y", want.y, pixel_y);
				if (pixel_color !== want.color)
					flag_mismatch("pixel_color", want.color, pixel_color);
				if (last_pixel !== want.last)
					flag_mismatch("last_pixel", 16'(want.last), 16'(last_pixel));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		// Directed part: unprintable codes, rows past the store, single pixels at the
		// wrap point, an empty glyph, zero width and height, an oversized width, and
		// writes to unmapped register indexes
		directed_plan = '{
			draw_blank(8'h00, 16'h0000, 16'h0000, 16'h0000),
			draw_blank(8'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			draw_blank(8'hFF, 16'h1234, 16'h5678, 16'h9ABC),
			cfg_row(REG_FONT_HEIGHT, 4'd1),
			load_row(10'd0, 8'h80),
			draw_single(8'h20, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				'{x: 16'hFFFF, y: 16'hFFFF, color: 16'hFFFF, last: 1'b1}),
			load_row(10'd0, 8'h01),
			draw_single(8'h20, 16'hFFFF, 16'h0000, 16'h0000,
				'{x: 16'h0006, y: 16'h0000, color: 16'h0000, last: 1'b1}),
			load_row(10'd1, 8'hFF),
			draw_row(8'h21, 16'hFFF9, 16'h1234, 16'hA5A5),
			load_row(10'd2, 8'h00),
			draw_blank(8'h22, 16'h0100, 16'h0200, 16'hFFFF),
			load_row(10'h3FF, 8'h5A),
			cfg_row(REG_FONT_WIDTH, 4'd0),
			draw_blank(8'h21, 16'h4000, 16'h0040, 16'h1234),
			cfg_row(REG_FONT_WIDTH, 4'd15),
			draw_row(8'h21, 16'h0000, 16'h0000, 16'h5555),
			cfg_row(REG_FONT_WIDTH, 4'd4),
			cfg_row(REG_FONT_HEIGHT, 4'd0),
			draw_blank(8'h21, 16'h0010, 16'h0020, 16'hAAAA),
			cfg_row(REG_FONT_HEIGHT, 4'd1),
			cfg_row(REG_UNMAPPED_2, 4'hF),
			cfg_row(REG_UNMAPPED_3, 4'h0),
			draw_row(8'h21, 16'h8000, 16'h7FFF, 16'h0F0F)
		};

		// hold reset, then release it at a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				program_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			end else begin
				send_item(directed_plan[i].cmd, !directed_plan[i].typed);
				if (directed_plan[i].typed && directed_plan[i].has_pixel)
					expected_pixels.push_back(directed_plan[i].pixel);
			end
		end

		// Random part: walk through font shapes, extremes included
		for (int p = 0; p < NUM_PHASES; p++) begin
			program_reg(REG_FONT_WIDTH, phase_w[p]);
			program_reg(REG_FONT_HEIGHT, phase_h[p]);
			steady_flow = (p == STEADY_PHASE);
			run_phase(PHASE_ITEMS);
		end
		steady_flow = 1'b0;

		// drain, then give stray pixels time to show up
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
